>>> rtl/rfjr_pkg.sv
// Shared types and constants for the range filter with jump rejection.
package rfjr_pkg;

  localparam int unsigned DistW     = 16;
  localparam int unsigned JumpW     = 4;
  localparam int unsigned SilenceW  = 12;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  // Default depth of the queue between the front and back parts
  localparam int unsigned QueueDepthDefault = 2;

  // Register reset values
  localparam logic [DistW-1:0]    JumpThresholdRst = 16'd300;
  localparam logic [JumpW-1:0]    JumpsToAcceptRst = 4'd3;
  localparam logic [DistW-1:0]    OorLevelRst      = 16'd8190;
  localparam logic [SilenceW-1:0] TimeoutTicksRst  = 12'd500;

  typedef enum logic [CfgIdxW-1:0] {
    CfgJumpThreshold = 2'd0,
    CfgJumpsToAccept = 2'd1,
    CfgOorLevel      = 2'd2,
    CfgTimeoutTicks  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [DistW-1:0]    jump_threshold;
    logic [JumpW-1:0]    jumps_to_accept;
    logic [DistW-1:0]    oor_level;
    logic [SilenceW-1:0] timeout_ticks;
  } cfg_t;

  // Classified item as it travels from the front to the back part
  typedef struct packed {
    logic             is_tick;
    logic             oor;
    logic [DistW-1:0] reading;
  } item_t;

endpackage

>>> rtl/rfjr_if.sv
// Handshake channels for input items and result items.
interface rfjr_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] reading;

  modport source (output valid, output func, output reading, input ready);
  modport sink   (input valid, input func, input reading, output ready);
endinterface

interface rfjr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] distance;
  logic        out_of_range;
  logic        jump_held;
  logic        reset_request;

  modport source (output valid, output distance, output out_of_range,
                  output jump_held, output reset_request, input ready);
  modport sink   (input valid, input distance, input out_of_range,
                  input jump_held, input reset_request, output ready);
endinterface

>>> rtl/rfjr_front.sv
// Front part: accepts input transactions and classifies them for the back part.
module rfjr_front import rfjr_pkg::*; (
  rfjr_in_if.sink          in_if,
  input  logic [DistW-1:0] oor_level_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output item_t            push_item_o
);

  // Accept whenever the queue has room
  assign in_if.ready  = push_ready_i;
  assign push_valid_o = in_if.valid;

  // Tag ticks and out-of-range readings
  always_comb begin
    push_item_o.is_tick = in_if.func;
    push_item_o.reading = in_if.reading;
    push_item_o.oor     = !in_if.func && (in_if.reading >= oor_level_i);
  end

endmodule

>>> rtl/rfjr_queue.sv
// Short queue of classified items between the front and back parts.
module rfjr_queue import rfjr_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output item_t pop_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           store_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = store_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Write the entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> rtl/rfjr_back.sv
// Back part: filter state, jump rejection, silence timer and result register.
module rfjr_back import rfjr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        pop_valid_i,
  output logic        pop_ready_o,
  input  item_t       pop_item_i,
  rfjr_out_if.source  out_if
);

  // Divide by ten as multiply by ceil(2^23/10), exact for 20-bit sums
  localparam int unsigned SumW   = 20;
  localparam int unsigned Shift  = 23;
  localparam logic [SumW-1:0] Recip = SumW'(((1 << Shift) + 9) / 10);

  logic [DistW-1:0]    hist_q, hist_d;
  logic                primed_q, primed_d;
  logic [JumpW-1:0]    jcnt_q, jcnt_d;
  logic [DistW-1:0]    dist_q, dist_d;
  logic [SilenceW-1:0] silence_q, silence_d;

  logic                valid_q;
  logic [DistW-1:0]    res_dist_q;
  logic                res_oor_q, res_oor_d;
  logic                res_held_q, res_held_d;
  logic                res_req_q, res_req_d;

  logic                advance, take;
  logic [DistW-1:0]    hist_eff, rd, diff;
  logic [SumW-1:0]     sum;
  logic [2*SumW-1:0]   prod;
  logic [DistW-1:0]    blend;
  logic                normal;
  logic [JumpW-1:0]    jcnt_inc;
  logic [SilenceW-1:0] silence_inc;

  // Result register frees up when empty or being taken
  assign advance     = !valid_q || out_if.ready;
  assign pop_ready_o = advance;
  assign take        = advance && pop_valid_i;

  // Blend and jump arithmetic
  assign rd       = pop_item_i.reading;
  assign hist_eff = primed_q ? hist_q : rd;
  assign diff     = (rd > hist_eff) ? (rd - hist_eff) : (hist_eff - rd);
  assign sum      = (SumW'(hist_eff) * SumW'(3)) + (SumW'(rd) * SumW'(7));
  assign prod     = (2*SumW)'(sum) * (2*SumW)'(Recip);
  assign blend    = prod[Shift +: DistW];
  assign normal   = (diff < cfg_i.jump_threshold) || (hist_eff == '0) ||
                    (hist_eff >= cfg_i.oor_level);
  assign jcnt_inc = jcnt_q + JumpW'(1);
  assign silence_inc = (silence_q != '1) ? silence_q + SilenceW'(1) : silence_q;

  // Next state for one item
  always_comb begin
    hist_d     = hist_q;
    primed_d   = primed_q;
    jcnt_d     = jcnt_q;
    dist_d     = dist_q;
    silence_d  = silence_q;
    res_oor_d  = 1'b0;
    res_held_d = 1'b0;
    res_req_d  = 1'b0;
    if (pop_item_i.is_tick) begin
      silence_d = silence_inc;
      if (silence_inc > cfg_i.timeout_ticks) begin
        res_req_d = 1'b1;
        silence_d = '0;
      end
    end else begin
      silence_d = '0;
      if (pop_item_i.oor) begin
        dist_d    = cfg_i.oor_level;
        res_oor_d = 1'b1;
      end else begin
        primed_d = 1'b1;
        hist_d   = hist_eff;
        if (normal) begin
          dist_d = blend;
          hist_d = blend;
          jcnt_d = '0;
        end else if (jcnt_inc >= cfg_i.jumps_to_accept) begin
          dist_d = rd;
          hist_d = rd;
          jcnt_d = '0;
        end else begin
          jcnt_d     = jcnt_inc;
          res_held_d = 1'b1;
        end
      end
    end
  end

  // Hold filter state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q    <= '0;
      primed_q  <= 1'b0;
      jcnt_q    <= '0;
      dist_q    <= '0;
      silence_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      if (take) begin
        hist_q    <= hist_d;
        primed_q  <= primed_d;
        jcnt_q    <= jcnt_d;
        dist_q    <= dist_d;
        silence_q <= silence_d;
      end
      if (advance) begin
        valid_q <= pop_valid_i;
      end
    end
  end

  // Load result payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      res_dist_q <= dist_d;
      res_oor_q  <= res_oor_d;
      res_held_q <= res_held_d;
      res_req_q  <= res_req_d;
    end
  end

  assign out_if.valid         = valid_q;
  assign out_if.distance      = res_dist_q;
  assign out_if.out_of_range  = res_oor_q;
  assign out_if.jump_held     = res_held_q;
  assign out_if.reset_request = res_req_q;

endmodule

>>> rtl/range_filter_jump_reject.sv
// Range filter with jump rejection and silence timeout: top level.
// Takes one transaction per clock cycle unless the output stalls,
// either a distance reading or a one-millisecond tick, and returns one
// result per transaction. Each transaction is registered in the queue
// behind the input classifier, then its result in the result register
// of the filter stage, whose state update (blend, divide by ten through
// a reciprocal multiply, jump compare) sets that rate.
// Input and output stall independently; the queue holds QueueDepth items.
// Write the registers only while no transaction is in flight.
module range_filter_jump_reject import rfjr_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  rfjr_in_if.sink             in_if,
  rfjr_out_if.source          out_if,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t  cfg_q;
  logic  push_valid, push_ready, pop_valid, pop_ready;
  item_t push_item, pop_item;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.jump_threshold  <= JumpThresholdRst;
      cfg_q.jumps_to_accept <= JumpsToAcceptRst;
      cfg_q.oor_level       <= OorLevelRst;
      cfg_q.timeout_ticks   <= TimeoutTicksRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgJumpThreshold: cfg_q.jump_threshold  <= cfg_data_i;
        CfgJumpsToAccept: cfg_q.jumps_to_accept <= cfg_data_i[JumpW-1:0];
        CfgOorLevel:      cfg_q.oor_level       <= cfg_data_i;
        CfgTimeoutTicks:  cfg_q.timeout_ticks   <= cfg_data_i[SilenceW-1:0];
      endcase
    end
  end

  rfjr_front u_front (
    .in_if        (in_if),
    .oor_level_i  (cfg_q.oor_level),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  rfjr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  rfjr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_if      (out_if)
  );

endmodule

>>> dv/rfjr_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the range filter: predicts every result and compares it with the output.
module rfjr_checker import rfjr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  rfjr_in_if                  in_mon,
  rfjr_out_if                 out_mon,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             out_of_range;
    logic             jump_held;
    logic             reset_request;
  } filter_result_t;

  // Register shadow and filter state
  cfg_t                cfg;
  logic [DistW-1:0]    history;
  logic                primed;
  logic [JumpW-1:0]    jump_cnt;
  logic [DistW-1:0]    distance;
  logic [SilenceW-1:0] silence;

  filter_result_t      expected_q[$];
  int unsigned         fail_count = 0;

  assign fail_count_o = fail_count;

  // Advance the filter by one transaction and return the result it produces
  function automatic filter_result_t filter_step(input logic is_tick,
                                                 input logic [DistW-1:0] rd);
    filter_result_t res;
    int unsigned    diff;
    int unsigned    blend;
    res = '0;
    if (is_tick) begin
      // Count silence, saturating; restart after a reset request
      if (silence != '1) silence = silence + 1'b1;
      if (silence > cfg.timeout_ticks) begin
        res.reset_request = 1'b1;
        silence = '0;
      end
    end else begin
      silence = '0;
      if (rd >= cfg.oor_level) begin
        // No object: report the level, keep the history
        distance = cfg.oor_level;
        res.out_of_range = 1'b1;
      end else begin
        if (!primed) begin
          history = rd;
          primed = 1'b1;
        end
        diff = (rd > history) ? rd - history : history - rd;
        if (diff < cfg.jump_threshold || history == '0 || history >= cfg.oor_level) begin
          // Blend 30% old with 70% new, truncated
          blend = (32'd3 * history + 32'd7 * rd) / 32'd10;
          distance = blend[DistW-1:0];
          history = distance;
          jump_cnt = '0;
        end else begin
          // Hold on a jump until enough consecutive jumps are seen
          jump_cnt = jump_cnt + 1'b1;
          if (jump_cnt >= cfg.jumps_to_accept) begin
            distance = rd;
            history = rd;
            jump_cnt = '0;
          end else begin
            res.jump_held = 1'b1;
          end
        end
      end
    end
    res.distance = distance;
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Track register writes, queue predictions, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    filter_result_t want;
    if (!rst_ni) begin
      cfg = '{jump_threshold: JumpThresholdRst, jumps_to_accept: JumpsToAcceptRst,
              oor_level: OorLevelRst, timeout_ticks: TimeoutTicksRst};
      history  = '0;
      primed   = 1'b0;
      jump_cnt = '0;
      distance = '0;
      silence  = '0;
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgJumpThreshold: cfg.jump_threshold  = cfg_data_i;
          CfgJumpsToAccept: cfg.jumps_to_accept = cfg_data_i[JumpW-1:0];
          CfgOorLevel:      cfg.oor_level       = cfg_data_i;
          CfgTimeoutTicks:  cfg.timeout_ticks   = cfg_data_i[SilenceW-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_q.push_back(filter_step(in_mon.func, in_mon.reading));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no transaction pending: distance %0d", out_mon.distance);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("distance", want.distance, out_mon.distance);
          check_field("out_of_range", want.out_of_range, out_mon.out_of_range);
          check_field("jump_held", want.jump_held, out_mon.jump_held);
          check_field("reset_request", want.reset_request, out_mon.reset_request);
        end
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

>>> dv/tb_range_filter_jump_reject.sv
`timescale 1ns / 100ps
// Testbench top: drives readings, ticks and register writes and gives the verdict.
module tb_range_filter_jump_reject;
  import rfjr_pkg::*;

  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned PhaseItems = 100;
  localparam int unsigned NumPhases  = 8;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  int unsigned         fail_count;
  int unsigned         pending;

  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned idle_cycles   = 0;

  // Register values as last written, for shaping the stimulus
  int unsigned cur_thr     = JumpThresholdRst;
  int unsigned cur_jumps   = JumpsToAcceptRst;
  int unsigned cur_oor     = OorLevelRst;
  int unsigned cur_timeout = TimeoutTicksRst;
  int unsigned level;
  int unsigned sent;

  rfjr_in_if  in_ch();
  rfjr_out_if out_ch();

  range_filter_jump_reject dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  rfjr_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #2 clk_i = ~clk_i;

  // Stall the result channel at random
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Abort when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one transaction after random idle cycles and hold it until accepted
  task automatic send_item(input logic is_tick, input logic [DistW-1:0] rd);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.func    <= is_tick;
    in_ch.reading <= rd;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  // Stop sending until every result is back, then let the pipeline settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(input int unsigned thr, input int unsigned jumps,
                              input int unsigned oor, input int unsigned timeout);
    cfg_idx_e    regs [4] = '{CfgJumpThreshold, CfgJumpsToAccept, CfgOorLevel,
                              CfgTimeoutTicks};
    int unsigned value [4];
    value = '{thr, jumps, oor, timeout};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= regs[i];
      cfg_data_i <= value[i][CfgDataW-1:0];
      @(posedge clk_i);
    end
    cfg_we_i    <= 1'b0;
    cur_thr     = thr;
    cur_jumps   = jumps;
    cur_oor     = oor;
    cur_timeout = timeout;
  endtask

  // Mostly a wandering distance with jump streaks and tick bursts, plus noise
  task automatic send_random_item();
    int unsigned pick;
    int unsigned spread;
    int unsigned lo;
    int unsigned hi;
    int unsigned burst;
    pick   = $urandom_range(99);
    spread = (cur_thr > 2) ? cur_thr / 2 : 1;
    if (spread > 400) spread = 400;
    if (pick < 3) begin
      burst = (cur_timeout <= 64) ? $urandom_range(cur_timeout + 2, 1) : 1;
      repeat (burst) send_item(1'b1, 16'($urandom));
    end else if (pick < 30) begin
      send_item(1'b1, 16'($urandom));
    end else if (pick < 36) begin
      send_item(1'b0, 16'($urandom_range(65535, cur_oor)));
    end else if (pick < 40) begin
      send_item(1'b0, 16'($urandom));
    end else begin
      burst = 1;
      if (pick < 52) begin
        // Jump to a new level and stay near it for a random run of readings
        level = $urandom_range(cur_oor - 1, 0);
        burst = $urandom_range(cur_jumps + 1, 1);
      end
      repeat (burst) begin
        lo    = (level > spread) ? level - spread : 0;
        hi    = (level + spread < cur_oor) ? level + spread : cur_oor - 1;
        level = $urandom_range(hi, lo);
        send_item(1'b0, 16'(level));
      end
    end
  endtask

  initial begin
    int unsigned thr;
    int unsigned jumps;
    int unsigned oor;
    int unsigned timeout;

    rst_ni        <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.func    <= 1'b0;
    in_ch.reading <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CfgJumpThreshold;
    cfg_data_i    <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: out of range before priming, pass-through, blend, jump hold and
    // acceptance, jump count cleared by a normal reading, zero history
    send_item(1'b1, 16'h0000);
    send_item(1'b1, 16'hFFFF);
    send_item(1'b0, 16'd65535);
    send_item(1'b0, 16'd8190);
    send_item(1'b0, 16'd1234);
    send_item(1'b0, 16'd1300);
    repeat (3) send_item(1'b0, 16'd5000);
    send_item(1'b0, 16'd5100);
    send_item(1'b0, 16'd100);
    send_item(1'b0, 16'd5050);
    repeat (3) send_item(1'b0, 16'd100);
    repeat (4) send_item(1'b0, 16'd0);
    send_item(1'b0, 16'd8189);
    send_item(1'b0, 16'd8189);
    send_item(1'b0, 16'd40000);
    send_item(1'b1, 16'h5A5A);
    drain();

    // Random phases, each with its own registers and idling pattern
    for (int p = 0; p < NumPhases; p++) begin
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 85; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 85; end
        default: begin src_idle_pct = 13; snk_stall_pct = 13; end
      endcase
      thr     = $urandom_range(3000, 50);
      jumps   = $urandom_range(15, 1);
      oor     = $urandom_range(65535, 2000);
      timeout = $urandom_range(40, 1);
      if (p == 0) begin
        thr     = 1;
        jumps   = 15;
        oor     = 65535;
        timeout = 1;
      end
      if (p == 4) begin
        thr     = 65535;
        jumps   = 1;
        timeout = 4095;
      end
      if (p == 6) oor = 1;
      write_config(thr, jumps, oor, timeout);
      level = $urandom_range(cur_oor - 1, 0);
      sent  = 0;
      while (sent < PhaseItems) send_random_item();
      drain();
    end

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
